/* hw/rtl/irt_pkg.sv */
// Shared types and constants of the IPv4 route table.
// No dependencies; the top level and irt_cell import this package.
`default_nettype none
package irt_pkg;

	localparam int TABLE_DEPTH_DEF = 128;

	typedef enum logic [1:0] {
		CMD_ADD     = 2'd0,
		CMD_DEL     = 2'd1,
		CMD_LOOKUP  = 2'd2,
		CMD_DEFAULT = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_MISS  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] dest;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic [47:0] mac;
		logic [7:0]  metric;
		logic        dflt;
	} entry_t;

endpackage
`default_nettype wire

/* hw/rtl/irt_req_if.sv */
// Request channel of the route table: valid/ready plus one command word.
// No dependencies.
`default_nettype none
interface irt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] ip_addr;
	logic [31:0] net_mask;
	logic [31:0] gw_addr;
	logic [47:0] gateway_mac;
	logic [7:0]  route_metric;
	logic        default_flag;

	modport source (
		output valid, cmd, ip_addr, net_mask, gw_addr, gateway_mac,
			route_metric, default_flag,
		input  ready
	);
	modport sink (
		input  valid, cmd, ip_addr, net_mask, gw_addr, gateway_mac,
			route_metric, default_flag,
		output ready
	);
endinterface
`default_nettype wire

/* hw/rtl/irt_rsp_if.sv */
// Response channel of the route table: valid/ready plus one result word.
// No dependencies.
`default_nettype none
interface irt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [6:0]  hit_index;
	logic [31:0] out_dst_ip;
	logic [31:0] out_mask;
	logic [31:0] out_gw_addr;
	logic [47:0] out_gateway_mac;
	logic [7:0]  out_metric;
	logic        out_default;

	modport source (
		output valid, status, hit_index, out_dst_ip, out_mask, out_gw_addr,
			out_gateway_mac, out_metric, out_default,
		input  ready
	);
	modport sink (
		input  valid, status, hit_index, out_dst_ip, out_mask, out_gw_addr,
			out_gateway_mac, out_metric, out_default,
		output ready
	);
endinterface
`default_nettype wire

/* hw/rtl/ip_route_table_first_match_unit.sv */
// Top level of the IPv4 route table: ring of entry cells plus scan control.
// Depends on irt_pkg, irt_req_if, irt_rsp_if and irt_cell.
//
//   channel | modport | word carries
//   --------+---------+-------------------------------------------------
//   req     | sink    | cmd, ip_addr, net_mask, gw_addr, gateway_mac,
//           |         | route_metric, default_flag
//   rsp     | source  | status, hit_index, out_dst_ip, out_mask,
//           |         | out_gw_addr, out_gateway_mac, out_metric, out_default
//
// Each command is accepted in S_IDLE, then S_SCAN rotates the ring of cells
// one full turn past the head cell, then S_FLUSH moves the result into the
// output register. A delete, lookup or get-default on an empty table skips
// the rotation and goes straight to S_FLUSH. Reset clears all valid bits and
// the route count at once; there is no clearing pass. A stalled rsp holds its
// word in the output register; the next command is still accepted and scanned,
// and its finished result waits with req.ready low until the output register
// frees.
`default_nettype none
module ip_route_table_first_match_unit import irt_pkg::*; #(
	parameter int DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	irt_req_if.sink   req,
	irt_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(DEPTH - 1);

	state_t state_q, state_d;

	// Ring of cells: cell k loads from cell k+1, the tail loads the head
	// entry after the controller has edited it. After DEPTH shifts the ring
	// is back in its original order.
	entry_t ring [DEPTH];
	entry_t head;
	entry_t tail_d;
	logic   scan_en;

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		if (k == DEPTH - 1) begin : g_tail
			irt_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (scan_en),
				.d      (tail_d),
				.q      (ring[k])
			);
		end else begin : g_body
			irt_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (scan_en),
				.d      (ring[k+1]),
				.q      (ring[k])
			);
		end
	end

	assign head = ring[0];

	// Captured request.
	cmd_t        cmd_q;
	logic [31:0] ip_q;
	logic [31:0] mask_q;
	logic [31:0] gw_q;
	logic [47:0] mac_q;
	logic [7:0]  met_q;
	logic        dfl_q;

	logic [IDX_W-1:0] step_q;
	logic             done_q;
	logic [CNT_W-1:0] count_q;

	// Pending result, built during the scan.
	status_t          res_status_q;
	logic [IDX_W-1:0] res_idx_q;
	entry_t           res_entry_q;

	// Output register.
	logic        rsp_valid_q;
	logic [1:0]  out_status_q;
	logic [6:0]  out_idx_q;
	entry_t      out_entry_q;

	logic   accept;
	logic   load_out;
	logic   is_empty;
	logic   take;
	logic   stop;
	logic   in_range;
	logic   last;
	entry_t new_entry;

	assign accept   = req.valid && req.ready;
	assign is_empty = (count_q == '0);
	assign last     = (step_q == LAST_STEP);
	assign in_range = (CNT_W'(step_q) < count_q);

	always_comb begin
		new_entry.valid   = 1'b1;
		new_entry.dest    = ip_q;
		new_entry.mask    = mask_q;
		new_entry.gateway = gw_q;
		new_entry.mac     = mac_q;
		new_entry.metric  = met_q;
		new_entry.dflt    = dfl_q;
	end

	// Match at the head cell; stop marks the end of the valid run.
	always_comb begin
		take = 1'b0;
		stop = 1'b0;
		case (cmd_q)
			CMD_ADD: begin
				take = !head.valid;
			end
			CMD_DEL: begin
				take = head.valid && (head.dest == ip_q) && (head.mask == mask_q)
					&& (head.gateway == gw_q);
				stop = !head.valid;
			end
			CMD_LOOKUP: begin
				take = head.valid && in_range
					&& ((ip_q & head.mask) == (head.dest & head.mask));
				stop = !head.valid || !in_range;
			end
			CMD_DEFAULT: begin
				take = head.valid && in_range && head.dflt;
				stop = !head.valid || !in_range;
			end
			default: begin
				take = 1'b0;
				stop = 1'b1;
			end
		endcase
	end

	// Write a new route into the first free slot, or drop a deleted one.
	always_comb begin
		tail_d = head;
		if (!done_q && take) begin
			if (cmd_q == CMD_ADD) begin
				tail_d = new_entry;
			end else if (cmd_q == CMD_DEL) begin
				tail_d.valid = 1'b0;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (cmd_t'(req.cmd) != CMD_ADD && is_empty) begin
						state_d = S_FLUSH;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (last) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State outputs.
	always_comb begin
		req.ready = 1'b0;
		scan_en   = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
			end
			S_SCAN: begin
				scan_en = 1'b1;
			end
			S_FLUSH: begin
				load_out = !rsp_valid_q || rsp.ready;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Scan control and route count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else if (accept) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else if (scan_en) begin
			step_q <= last ? '0 : step_q + 1'b1;
			if (!done_q && (take || stop)) begin
				done_q <= 1'b1;
			end
			if (!done_q && take) begin
				if (cmd_q == CMD_ADD) begin
					count_q <= count_q + 1'b1;
				end else if (cmd_q == CMD_DEL) begin
					count_q <= count_q - 1'b1;
				end
			end
		end
	end

	// Hold the request and build the result.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q        <= cmd_t'(req.cmd);
			ip_q         <= req.ip_addr;
			mask_q       <= req.net_mask;
			gw_q         <= req.gw_addr;
			mac_q        <= req.gateway_mac;
			met_q        <= req.route_metric;
			dfl_q        <= req.default_flag;
			res_idx_q    <= '0;
			res_entry_q  <= '0;
			if (cmd_t'(req.cmd) == CMD_ADD) begin
				res_status_q <= ST_FULL;
			end else if (is_empty) begin
				res_status_q <= ST_EMPTY;
			end else begin
				res_status_q <= ST_MISS;
			end
		end else if (scan_en && !done_q && take) begin
			res_status_q <= ST_OK;
			res_idx_q    <= step_q;
			res_entry_q  <= (cmd_q == CMD_ADD) ? new_entry : head;
		end
	end

	// Output register; advance when the sink takes the word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= res_status_q;
			out_idx_q    <= 7'(res_idx_q);
			out_entry_q  <= res_entry_q;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = out_status_q;
	assign rsp.hit_index       = out_idx_q;
	assign rsp.out_dst_ip      = out_entry_q.dest;
	assign rsp.out_mask        = out_entry_q.mask;
	assign rsp.out_gw_addr     = out_entry_q.gateway;
	assign rsp.out_gateway_mac = out_entry_q.mac;
	assign rsp.out_metric      = out_entry_q.metric;
	assign rsp.out_default     = out_entry_q.dflt;

endmodule
`default_nettype wire

/* hw/rtl/irt_cell.sv */
// One route entry of the rotating table; passes its entry on when shifted.
// Depends on irt_pkg.
`default_nettype none
module irt_cell import irt_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   shift,
	input  wire entry_t d,
	output entry_t      q
);

	logic valid_q;
	entry_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= d;
		end
	end

	always_comb begin
		q = data_q;
		q.valid = valid_q;
	end

endmodule
`default_nettype wire
